// File: rtl/core/mppmfr_pkg.sv
// Shared types and constants for the MPPM frame receiver.
package mppmfr_pkg;

  localparam int unsigned SYNC_W    = 16;
  localparam int unsigned WPF_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CIDX_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_FRAME = 1'd1;

  localparam logic [SYNC_W-1:0] SYNC_PATTERN_RST    = 16'hAAAA;
  localparam logic [WPF_W-1:0]  WORDS_PER_FRAME_RST = 4'd9;

  localparam logic [1:0] MODE_HUNT = 2'd0;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  localparam logic [CIDX_W-1:0] LAST_CHIP = 4'd15;

  // decoded result request
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
  } res_t;

endpackage

// File: rtl/core/mppmfr_core.sv
// Hunt, sync-match and symbol-decode state for the MPPM frame receiver.
module mppmfr_core #(
  parameter int unsigned HEADER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 chip_acc,
  input  logic                                 chip,
  input  logic [mppmfr_pkg::SYNC_W-1:0]        sync_pattern,
  input  logic [mppmfr_pkg::WPF_W-1:0]         words_per_frame,
  output mppmfr_pkg::res_t                     res
);

  localparam int unsigned CMP_W = (HEADER_BITS < mppmfr_pkg::SYNC_W) ?
                                  HEADER_BITS : mppmfr_pkg::SYNC_W;

  logic [1:0]                          mode_r, mode_nxt;
  logic [HEADER_BITS-1:0]              hdr_r, hdr_nxt;
  logic [mppmfr_pkg::CIDX_W-1:0]       cidx_r, cidx_nxt;
  logic [2:0]                          sym_r, sym_nxt;
  logic [mppmfr_pkg::BYTE_W-1:0]       word_r, word_nxt;
  logic [mppmfr_pkg::WPF_W-1:0]        cnt_r, cnt_nxt;

  logic [HEADER_BITS-1:0]              sync_cmp;
  logic [HEADER_BITS-1:0]              hdr_base;
  logic [HEADER_BITS-1:0]              hdr_shift;
  logic [2:0]                          sym_shift;
  logic [1:0]                          pos;
  logic [mppmfr_pkg::WPF_W-1:0]        cnt_inc;
  logic                                sym_ok;
  logic [1:0]                          sym_bits;

  always_comb begin
    sync_cmp = '0;
    sync_cmp[CMP_W-1:0] = sync_pattern[CMP_W-1:0];
  end

  // header starts from zero on the first high chip in hunt
  assign hdr_base  = (mode_r == mppmfr_pkg::MODE_SYNC) ? hdr_r : '0;
  assign hdr_shift = {hdr_base[HEADER_BITS-2:0], chip};
  assign pos       = cidx_r[1:0];
  assign sym_shift = {sym_r[1:0], chip};
  assign cnt_inc   = mppmfr_pkg::WPF_W'(cnt_r + 1'b1);

  always_comb begin
    sym_ok   = 1'b1;
    sym_bits = 2'b00;
    case (sym_shift)
      3'b001:  sym_bits = 2'b10;
      3'b011:  sym_bits = 2'b01;
      3'b110:  sym_bits = 2'b00;
      3'b101:  sym_bits = 2'b11;
      default: sym_ok   = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    hdr_nxt       = hdr_r;
    cidx_nxt      = cidx_r;
    sym_nxt       = sym_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    res.valid     = 1'b0;
    res.data_byte = word_r;
    res.frame_end = 1'b0;
    if (chip_acc) begin
      case (mode_r)
        mppmfr_pkg::MODE_DATA: begin
          if (pos != 2'd3) sym_nxt = sym_shift;
          else             sym_nxt = '0;
          if (pos == 2'd2 && sym_ok) word_nxt = {word_r[5:0], sym_bits};
          if (cidx_r != mppmfr_pkg::LAST_CHIP) begin
            cidx_nxt = mppmfr_pkg::CIDX_W'(cidx_r + 1'b1);
          end else begin
            res.valid = 1'b1;
            cidx_nxt  = '0;
            sym_nxt   = '0;
            word_nxt  = '0;
            cnt_nxt   = cnt_inc;
            if (cnt_inc == words_per_frame) begin
              res.frame_end = 1'b1;
              mode_nxt      = mppmfr_pkg::MODE_HUNT;
              hdr_nxt       = '0;
              cnt_nxt       = '0;
            end
          end
        end
        mppmfr_pkg::MODE_SYNC: begin
          hdr_nxt = hdr_shift;
          if (hdr_shift == sync_cmp) begin
            mode_nxt = mppmfr_pkg::MODE_DATA;
            cidx_nxt = '0;
            sym_nxt  = '0;
            word_nxt = '0;
            cnt_nxt  = '0;
          end else begin
            mode_nxt = mppmfr_pkg::MODE_SYNC;
          end
        end
        default: begin
          if (chip) begin
            hdr_nxt = hdr_shift;
            if (hdr_shift == sync_cmp) begin
              mode_nxt = mppmfr_pkg::MODE_DATA;
              cidx_nxt = '0;
              sym_nxt  = '0;
              word_nxt = '0;
              cnt_nxt  = '0;
            end else begin
              mode_nxt = mppmfr_pkg::MODE_SYNC;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mppmfr_pkg::MODE_HUNT;
      hdr_r  <= '0;
      cidx_r <= '0;
      sym_r  <= '0;
      word_r <= '0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      hdr_r  <= hdr_nxt;
      cidx_r <= cidx_nxt;
      sym_r  <= sym_nxt;
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_res_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> mode_r == mppmfr_pkg::MODE_DATA)
    else $error("result outside data mode");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.frame_end |=> mode_r == mppmfr_pkg::MODE_HUNT && cnt_r == '0)
    else $error("frame end did not return to hunt");

  a_cidx_data: assert property (@(posedge clk) disable iff (!rst_n)
    cidx_r != '0 |-> mode_r == mppmfr_pkg::MODE_DATA)
    else $error("chip index running outside data mode");

endmodule

// File: rtl/core/mppmfr_out_buf.sv
// Output register with skid slot for decoded bytes.
module mppmfr_out_buf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mppmfr_pkg::res_t                push,
  output logic                            push_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mppmfr_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                            out_frame_end
);

  logic                          out_valid_r;
  logic [mppmfr_pkg::BYTE_W-1:0] out_byte_r;
  logic                          out_end_r;
  logic                          skid_valid_r;
  logic [mppmfr_pkg::BYTE_W-1:0] skid_byte_r;
  logic                          skid_end_r;
  logic                          pop;

  assign pop           = out_valid_r && out_ready;
  assign push_ready    = !skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_frame_end = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push.valid;
      end
    end else if (push.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_byte_r <= skid_byte_r;
        out_end_r  <= skid_end_r;
      end else if (push.valid) begin
        out_byte_r <= push.data_byte;
        out_end_r  <= push.frame_end;
      end
    end else if (push.valid) begin
      skid_byte_r <= push.data_byte;
      skid_end_r  <= push.frame_end;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot filled with output empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && skid_valid_r))
    else $error("result pushed while buffer full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output");

endmodule

// File: rtl/core/mppm_frame_receiver_unit.sv
// Top level of the MPPM frame receiver: config registers, decoder, output buffer.
//
// One sampled chip enters per request on the in_ channel (in_chip_level).
// The block hunts for a high chip, shifts chips into a HEADER_BITS header
// register until it equals cfg sync_pattern, then decodes 16-chip words of
// four 4-chip multipulse symbols. Each word yields one request on the out_
// channel with the low byte and a frame_end flag on the last word of a frame
// (words_per_frame words, 0 meaning 16), after which hunting resumes.
// Throughput: one chip per cycle while in_ready is high; the decoder's result is combinational.
// Each byte is pushed into the output buffer on the 16th chip of its word.
// A two-entry output buffer (output register plus skid slot) lets chips keep
// flowing while a byte waits; in_ready drops only when both entries are full,
// which only a stall on out_ready can bring about.
// Config writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect on the next chip.
// Reset (rst_n low, synchronous) loads sync 0xAAAA, 9 words per frame,
// empties the buffer and enters hunt.
module mppm_frame_receiver_unit #(
  parameter int unsigned HEADER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_chip_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mppmfr_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                                out_frame_end,
  input  logic                                cfg_wr_en,
  input  logic [mppmfr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mppmfr_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  logic [mppmfr_pkg::SYNC_W-1:0] sync_pattern_r;
  logic [mppmfr_pkg::WPF_W-1:0]  words_per_frame_r;
  logic                          chip_acc;
  mppmfr_pkg::res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r    <= mppmfr_pkg::SYNC_PATTERN_RST;
      words_per_frame_r <= mppmfr_pkg::WORDS_PER_FRAME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mppmfr_pkg::CFG_SYNC_PATTERN:    sync_pattern_r <= cfg_wdata;
        mppmfr_pkg::CFG_WORDS_PER_FRAME:
          words_per_frame_r <= cfg_wdata[mppmfr_pkg::WPF_W-1:0];
        default: ;
      endcase
    end
  end

  assign chip_acc = in_valid && in_ready;

  mppmfr_core #(
    .HEADER_BITS(HEADER_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .chip_acc        (chip_acc),
    .chip            (in_chip_level),
    .sync_pattern    (sync_pattern_r),
    .words_per_frame (words_per_frame_r),
    .res             (res)
  );

  mppmfr_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (res),
    .push_ready    (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_byte (out_data_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
